/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the heat stencil block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/hsc_pkg.sv */
// Types, constants and helper functions of the heat stencil block.
`default_nettype none

package hsc_pkg;

   localparam int POINTS = 1024;
   localparam int ADDR_W = $clog2(POINTS);
   localparam int CNT_W = $clog2(POINTS + 1);

   localparam int DATA_W = 32;
   localparam int SWEEPS_W = 16;
   localparam int SPREAD_LIMIT_W = 31;
   localparam int ROUNDS_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEPS_PER_ROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOWED_SPREAD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ROUNDS = 2'd2;

   localparam logic [SWEEPS_W-1:0] SWEEPS_RESET = 16'd1000;
   localparam logic [SPREAD_LIMIT_W-1:0] SPREAD_RESET = 31'd66;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 16'd65535;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   // The three-point magnitude (33 bits) is divided one nibble at a time.
   localparam int DIV_W = 36;
   localparam int DIV_NIBBLES = DIV_W / 4;
   localparam int DIV_STEP_W = $clog2(DIV_NIBBLES);

   typedef struct packed {
      logic [3:0] q;
      logic [1:0] r;
   } div3_digit_type;

   // One digit of a long division by three: v is the running remainder
   // followed by the next nibble, so it stays below 48.
   function automatic div3_digit_type div3_digit(input logic [5:0] v);
      div3_digit_type res;
      logic [5:0] prod;
      res.q = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (v >= 6'(3 * k)) begin
            res.q = 4'(k);
         end
      end
      prod = {2'b00, res.q} + {1'b0, res.q, 1'b0};
      res.r = 2'(v - prod);
      return res;
   endfunction

   // Halves a two-term sum, truncating toward zero.
   function automatic logic signed [DATA_W-1:0] half_to_zero(input logic [DATA_W:0] s);
      logic [DATA_W:0] t;
      t = s + {{DATA_W{1'b0}}, s[DATA_W]};
      return t[DATA_W:1];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/heat_stencil_converge_core.sv */
// Heat stencil core: loads a row of Q16.16 temperatures and smooths it until it is flat.
// Samples are taken one per cycle into a 1024-entry row memory; the item with
// last set starts the computation and the block holds req_stall high until the
// result is in the output register. Each sweep walks the row through the single
// memory read port and the nibble-serial divide-by-three unit: an interior point
// passes through fetch, operand, setup, nine divide steps and write back, while
// a point at either end of the row skips the divide. Every round ends with a
// min/max pass over the row and a check of the spread. A sweep that changes
// nothing ends the round early, and a round whose sweeps all changed nothing
// ends an unconverged run with rounds_done at the round limit. A max_rounds of
// zero acts as one; samples beyond 1024 are dropped.
`default_nettype none

`include "assert_macros.svh"

module heat_stencil_converge_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input items
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [hsc_pkg::DATA_W-1:0]   req_sample,
   input  wire logic                                req_last,
   // Result items
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic             [hsc_pkg::ROUNDS_W-1:0] rsp_rounds_done,
   output logic signed      [hsc_pkg::DATA_W-1:0]   rsp_min_value,
   output logic signed      [hsc_pkg::DATA_W-1:0]   rsp_max_value,
   output logic             [hsc_pkg::DATA_W-1:0]   rsp_spread,
   output logic                                     rsp_converged,
   // Configuration writes
   input  wire logic                                csr_we,
   input  wire logic [hsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [hsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SW_INIT,
      ST_SW_LOAD0,
      ST_SW_FETCH,
      ST_SW_RIGHT,
      ST_SW_CALC,
      ST_SW_DIV,
      ST_SW_WRITE,
      ST_SW_END,
      ST_MS_START,
      ST_MS_RUN,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [hsc_pkg::SWEEPS_W-1:0]       sweeps_ff, sweeps_in;
   logic [hsc_pkg::SPREAD_LIMIT_W-1:0] allowed_ff, allowed_in;
   logic [hsc_pkg::ROUNDS_W-1:0]       max_rounds_ff, max_rounds_in;

   logic [hsc_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [hsc_pkg::CNT_W-1:0]    n_ff, n_in;
   logic [hsc_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic [hsc_pkg::ROUNDS_W-1:0] round_ff, round_in;
   logic [hsc_pkg::SWEEPS_W-1:0] sweep_ff, sweep_in;
   logic                         round_chg_ff, round_chg_in;
   logic                         sweep_chg_ff, sweep_chg_in;
   logic                         conv_ff, conv_in;

   logic signed [hsc_pkg::DATA_W-1:0] left_ff, left_in;
   logic signed [hsc_pkg::DATA_W-1:0] cur_ff, cur_in;
   logic signed [hsc_pkg::DATA_W-1:0] right_ff, right_in;
   logic signed [hsc_pkg::DATA_W-1:0] nv_ff, nv_in;
   logic signed [hsc_pkg::DATA_W-1:0] min_ff, min_in;
   logic signed [hsc_pkg::DATA_W-1:0] max_ff, max_in;

   logic [hsc_pkg::DIV_W-1:0]      div_sh_ff, div_sh_in;
   logic [1:0]                     div_rem_ff, div_rem_in;
   logic [hsc_pkg::DATA_W-5:0]     div_q_ff, div_q_in;
   logic                           div_neg_ff, div_neg_in;
   logic [hsc_pkg::DIV_STEP_W-1:0] div_step_ff, div_step_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [hsc_pkg::ROUNDS_W-1:0]      rsp_rounds_ff, rsp_rounds_in;
   logic signed [hsc_pkg::DATA_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [hsc_pkg::DATA_W-1:0] rsp_max_ff, rsp_max_in;
   logic [hsc_pkg::DATA_W-1:0]        rsp_spread_ff, rsp_spread_in;
   logic                              rsp_conv_ff, rsp_conv_in;

   logic                              ram_we;
   logic [hsc_pkg::ADDR_W-1:0]        ram_waddr;
   logic [hsc_pkg::DATA_W-1:0]        ram_wdata;
   logic [hsc_pkg::ADDR_W-1:0]        ram_raddr;
   logic [hsc_pkg::DATA_W-1:0]        ram_rdata;

   logic signed [hsc_pkg::DATA_W-1:0] rd_value;
   logic [hsc_pkg::CNT_W-1:0]         idx_next;
   logic                              idx_is_last;
   logic                              has_right;
   logic [hsc_pkg::DATA_W:0]          sum_first;
   logic [hsc_pkg::DATA_W:0]          sum_last;
   logic [hsc_pkg::DATA_W+1:0]        sum_mid;
   logic [hsc_pkg::DATA_W+1:0]        sum_mid_mag;
   hsc_pkg::div3_digit_type           digit;
   logic [hsc_pkg::DATA_W-1:0]        quot_full;
   logic [hsc_pkg::DATA_W-1:0]        spread_w;
   logic [hsc_pkg::ROUNDS_W-1:0]      limit_w;

   hsc_ram #(
      .WIDTH (hsc_pkg::DATA_W),
      .DEPTH (hsc_pkg::POINTS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_value    = $signed(ram_rdata);
   assign idx_next    = hsc_pkg::CNT_W'(idx_ff) + hsc_pkg::CNT_W'(1);
   assign idx_is_last = (idx_next == n_ff);
   assign has_right   = (idx_next < n_ff);

   assign sum_first = {cur_ff[31], cur_ff} + {right_ff[31], right_ff};
   assign sum_last  = {left_ff[31], left_ff} + {cur_ff[31], cur_ff};
   assign sum_mid   = {{2{left_ff[31]}}, left_ff} + {{2{cur_ff[31]}}, cur_ff}
                    + {{2{right_ff[31]}}, right_ff};
   assign sum_mid_mag = sum_mid[hsc_pkg::DATA_W+1] ? (~sum_mid + 1'b1) : sum_mid;

   assign digit     = hsc_pkg::div3_digit({div_rem_ff, div_sh_ff[hsc_pkg::DIV_W-1 -: 4]});
   assign quot_full = {div_q_ff, digit.q};

   assign spread_w = max_ff - min_ff;
   assign limit_w  = (max_rounds_ff == '0) ? hsc_pkg::ROUNDS_W'(1) : max_rounds_ff;

   always_comb begin
      state_in      = state_ff;
      sweeps_in     = sweeps_ff;
      allowed_in    = allowed_ff;
      max_rounds_in = max_rounds_ff;
      fill_in       = fill_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      round_in      = round_ff;
      sweep_in      = sweep_ff;
      round_chg_in  = round_chg_ff;
      sweep_chg_in  = sweep_chg_ff;
      conv_in       = conv_ff;
      left_in       = left_ff;
      cur_in        = cur_ff;
      right_in      = right_ff;
      nv_in         = nv_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      div_sh_in     = div_sh_ff;
      div_rem_in    = div_rem_ff;
      div_q_in      = div_q_ff;
      div_neg_in    = div_neg_ff;
      div_step_in   = div_step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rounds_in = rsp_rounds_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_conv_in   = rsp_conv_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = nv_ff;
      ram_raddr     = idx_next[hsc_pkg::ADDR_W-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            hsc_pkg::CSR_SWEEPS_PER_ROUND: sweeps_in = csr_wdata[hsc_pkg::SWEEPS_W-1:0];
            hsc_pkg::CSR_ALLOWED_SPREAD:   allowed_in = csr_wdata;
            hsc_pkg::CSR_MAX_ROUNDS:       max_rounds_in = csr_wdata[hsc_pkg::ROUNDS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Samples past the end of the memory are dropped.
               if (fill_ff < hsc_pkg::CNT_W'(hsc_pkg::POINTS)) begin
                  ram_we    = 1'b1;
                  ram_waddr = fill_ff[hsc_pkg::ADDR_W-1:0];
                  ram_wdata = req_sample;
                  fill_in   = fill_ff + hsc_pkg::CNT_W'(1);
               end
               if (req_last) begin
                  n_in         = fill_in;
                  fill_in      = '0;
                  round_in     = hsc_pkg::ROUNDS_W'(1);
                  sweep_in     = '0;
                  round_chg_in = 1'b0;
                  conv_in      = 1'b0;
                  state_in     = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            state_in = (sweep_ff < sweeps_ff) ? ST_SW_INIT : ST_MS_START;
         end
         ST_SW_INIT: begin
            idx_in       = '0;
            left_in      = '0;
            sweep_chg_in = 1'b0;
            ram_raddr    = '0;
            state_in     = ST_SW_LOAD0;
         end
         ST_SW_LOAD0: begin
            cur_in   = rd_value;
            state_in = ST_SW_FETCH;
         end
         ST_SW_FETCH: begin
            state_in = has_right ? ST_SW_RIGHT : ST_SW_CALC;
         end
         ST_SW_RIGHT: begin
            right_in = rd_value;
            state_in = ST_SW_CALC;
         end
         ST_SW_CALC: begin
            if (n_ff == hsc_pkg::CNT_W'(1)) begin
               // A lone point has no neighbor and keeps its value.
               nv_in    = cur_ff;
               state_in = ST_SW_WRITE;
            end else if (idx_ff == '0) begin
               nv_in    = hsc_pkg::half_to_zero(sum_first);
               state_in = ST_SW_WRITE;
            end else if (idx_is_last) begin
               nv_in    = hsc_pkg::half_to_zero(sum_last);
               state_in = ST_SW_WRITE;
            end else begin
               div_sh_in   = hsc_pkg::DIV_W'(sum_mid_mag[hsc_pkg::DATA_W:0]);
               div_neg_in  = sum_mid[hsc_pkg::DATA_W+1];
               div_rem_in  = 2'd0;
               div_q_in    = '0;
               div_step_in = '0;
               state_in    = ST_SW_DIV;
            end
         end
         ST_SW_DIV: begin
            div_sh_in   = {div_sh_ff[hsc_pkg::DIV_W-5:0], 4'd0};
            div_rem_in  = digit.r;
            div_q_in    = quot_full[hsc_pkg::DATA_W-5:0];
            div_step_in = div_step_ff + hsc_pkg::DIV_STEP_W'(1);
            if (div_step_ff == hsc_pkg::DIV_STEP_W'(hsc_pkg::DIV_NIBBLES - 1)) begin
               nv_in    = div_neg_ff ? -$signed(quot_full) : $signed(quot_full);
               state_in = ST_SW_WRITE;
            end
         end
         ST_SW_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = nv_ff;
            if (nv_ff != cur_ff) begin
               sweep_chg_in = 1'b1;
            end
            left_in = cur_ff;
            cur_in  = right_ff;
            if (idx_is_last) begin
               state_in = ST_SW_END;
            end else begin
               idx_in   = idx_next[hsc_pkg::ADDR_W-1:0];
               state_in = ST_SW_FETCH;
            end
         end
         ST_SW_END: begin
            // A sweep that changed nothing leaves every later sweep idle too.
            if (sweep_chg_ff) begin
               round_chg_in = 1'b1;
               sweep_in     = sweep_ff + hsc_pkg::SWEEPS_W'(1);
               state_in     = ST_ROUND;
            end else begin
               state_in = ST_MS_START;
            end
         end
         ST_MS_START: begin
            idx_in    = '0;
            min_in    = hsc_pkg::VALUE_MAX;
            max_in    = hsc_pkg::VALUE_MIN;
            ram_raddr = '0;
            state_in  = ST_MS_RUN;
         end
         ST_MS_RUN: begin
            if (rd_value < min_ff) begin
               min_in = rd_value;
            end
            if (rd_value > max_ff) begin
               max_in = rd_value;
            end
            if (idx_is_last) begin
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_next[hsc_pkg::ADDR_W-1:0];
            end
         end
         ST_CHECK: begin
            if (spread_w < hsc_pkg::DATA_W'(allowed_ff)) begin
               conv_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (round_ff >= limit_w) begin
               state_in = ST_FINISH;
            end else if (!round_chg_ff) begin
               // The row is at rest: every remaining round would end the same.
               round_in = limit_w;
               state_in = ST_FINISH;
            end else begin
               round_in     = round_ff + hsc_pkg::ROUNDS_W'(1);
               sweep_in     = '0;
               round_chg_in = 1'b0;
               state_in     = ST_ROUND;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_rounds_in = round_ff;
               rsp_min_in    = min_ff;
               rsp_max_in    = max_ff;
               rsp_spread_in = spread_w;
               rsp_conv_in   = conv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sweeps_ff     <= hsc_pkg::SWEEPS_RESET;
         allowed_ff    <= hsc_pkg::SPREAD_RESET;
         max_rounds_ff <= hsc_pkg::ROUNDS_RESET;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweeps_ff     <= sweeps_in;
         allowed_ff    <= allowed_in;
         max_rounds_ff <= max_rounds_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      round_ff      <= round_in;
      sweep_ff      <= sweep_in;
      round_chg_ff  <= round_chg_in;
      sweep_chg_ff  <= sweep_chg_in;
      conv_ff       <= conv_in;
      left_ff       <= left_in;
      cur_ff        <= cur_in;
      right_ff      <= right_in;
      nv_ff         <= nv_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      div_sh_ff     <= div_sh_in;
      div_rem_ff    <= div_rem_in;
      div_q_ff      <= div_q_in;
      div_neg_ff    <= div_neg_in;
      div_step_ff   <= div_step_in;
      rsp_rounds_ff <= rsp_rounds_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_conv_ff   <= rsp_conv_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rounds_done = rsp_rounds_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_spread      = rsp_spread_ff;
   assign rsp_converged   = rsp_conv_ff;

   // A converged result must really lie below the threshold in force.
   `ASSERT_IMPLIES(a_conv_below_limit, clock, reset, rsp_valid && rsp_converged, rsp_spread < hsc_pkg::DATA_W'(allowed_ff), "converged item has spread at or above the threshold")
   // The reported spread is the distance between the reported extremes.
   `ASSERT_IMPLIES(a_spread_consistent, clock, reset, rsp_valid, (rsp_max_value >= rsp_min_value) && (rsp_spread == hsc_pkg::DATA_W'(rsp_max_value - rsp_min_value)), "result extremes and spread disagree")
   // Every result reports at least one round.
   `ASSERT_IMPLIES(a_rounds_nonzero, clock, reset, rsp_valid, rsp_rounds_done != '0, "result item reports zero rounds")
   // A new result is loaded only out of the finishing state.
   `ASSERT_NEXT(a_load_from_finish, clock, reset, !rsp_valid || !rsp_stall, !rsp_valid || ($past(state_ff) == ST_FINISH), "result appeared without a finished computation")

endmodule

`default_nettype wire

/* test/tb_heat_stencil_converge_core.sv */
// Testbench for the heat stencil core: row loading, smoothing rounds and result checks.
`timescale 1ns / 1ps

module tb_heat_stencil_converge_core;
   import hsc_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } row_sample_t;

   typedef struct {
      logic        [ROUNDS_W-1:0] rounds;
      logic signed [DATA_W-1:0]   lo;
      logic signed [DATA_W-1:0]   hi;
      logic        [DATA_W-1:0]   spread;
      logic                       converged;
   } row_summary_t;

   typedef enum int {FILL_WIDE, FILL_NARROW, FILL_FLAT, FILL_EDGES} fill_style_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [DATA_W-1:0]      req_sample = '0;
   logic                          req_last = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic        [ROUNDS_W-1:0]    rsp_rounds_done;
   logic signed [DATA_W-1:0]      rsp_min_value;
   logic signed [DATA_W-1:0]      rsp_max_value;
   logic        [DATA_W-1:0]      rsp_spread;
   logic                          rsp_converged;

   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   heat_stencil_converge_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rounds_done (rsp_rounds_done),
      .rsp_min_value   (rsp_min_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_spread      (rsp_spread),
      .rsp_converged   (rsp_converged),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   row_sample_t  samples_pending[$];
   row_summary_t summaries_due[$];
   int           mismatches = 0;
   bit           calm = 1'b0;
   bit           req_taken = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;

   // Shadow copy of the block's row memory and settings.
   logic signed [DATA_W-1:0] row_mem [POINTS];
   int unsigned row_fill = 0;
   int unsigned sweeps_cfg = SWEEPS_RESET;
   int unsigned spread_cfg = SPREAD_RESET;
   int unsigned rounds_cfg = ROUNDS_RESET;

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      $display("%0t ns: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Stores one sample and, on the row end, runs the rounds and queues the summary.
   task automatic absorb_sample(input logic signed [DATA_W-1:0] value, input logic is_last);
      int unsigned n, limit, r, t, i;
      bit round_changed, sweep_changed, done, conv;
      logic signed [DATA_W-1:0] cur, nv, left, lo, hi;
      logic [DATA_W-1:0] width;
      row_summary_t s;
      if (row_fill < POINTS) begin
         row_mem[row_fill] = value;
         row_fill++;
      end
      if (is_last) begin
         n = row_fill;
         limit = (rounds_cfg == 0) ? 1 : rounds_cfg;
         r = 0;
         done = 1'b0;
         conv = 1'b0;
         while (!done) begin
            r++;
            round_changed = 1'b0;
            for (t = 0; t < sweeps_cfg; t++) begin
               sweep_changed = 1'b0;
               left = '0;
               for (i = 0; i < n; i++) begin
                  cur = row_mem[i];
                  if (n == 1) begin
                     nv = cur;
                  end else if (i == 0) begin
                     nv = 32'((longint'(cur) + longint'(row_mem[1])) / 2);
                  end else if (i == n - 1) begin
                     nv = 32'((longint'(left) + longint'(cur)) / 2);
                  end else begin
                     nv = 32'((longint'(left) + longint'(cur) + longint'(row_mem[i + 1])) / 3);
                  end
                  if (nv != cur) sweep_changed = 1'b1;
                  row_mem[i] = nv;
                  left = cur;
               end
               // Once a sweep leaves the row unchanged, further sweeps would too.
               if (!sweep_changed) break;
               round_changed = 1'b1;
            end
            lo = VALUE_MAX;
            hi = VALUE_MIN;
            for (i = 0; i < n; i++) begin
               if (row_mem[i] < lo) lo = row_mem[i];
               if (row_mem[i] > hi) hi = row_mem[i];
            end
            width = hi - lo;
            if (width < spread_cfg) begin
               conv = 1'b1;
               done = 1'b1;
            end else if (r >= limit) begin
               done = 1'b1;
            end else if (!round_changed) begin
               r = limit;
               done = 1'b1;
            end
         end
         s.rounds = r[ROUNDS_W-1:0];
         s.lo = lo;
         s.hi = hi;
         s.spread = width;
         s.converged = conv;
         summaries_due.push_back(s);
         row_fill = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) absorb_sample(req_sample, req_last);
      end
   end

   always @(negedge clock) begin : drive_req
      row_sample_t item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (samples_pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            req_gap <= $urandom_range(0, 2);
         end else begin
            item = samples_pending.pop_front();
            req_valid <= 1'b1;
            req_sample <= item.value;
            req_last <= item.last;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         rsp_gap <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watch_rsp
      row_summary_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (summaries_due.size() == 0) begin
            flag_mismatch("result with none expected, rounds_done", 32'(rsp_rounds_done), '0);
         end else begin
            want = summaries_due.pop_front();
            if (rsp_rounds_done !== want.rounds)
               flag_mismatch("rounds_done", 32'(rsp_rounds_done), 32'(want.rounds));
            if (rsp_min_value !== want.lo)
               flag_mismatch("min_value", rsp_min_value, want.lo);
            if (rsp_max_value !== want.hi)
               flag_mismatch("max_value", rsp_max_value, want.hi);
            if (rsp_spread !== want.spread)
               flag_mismatch("spread", rsp_spread, want.spread);
            if (rsp_converged !== want.converged)
               flag_mismatch("converged", 32'(rsp_converged), 32'(want.converged));
         end
      end
   end

   task automatic push_sample(input logic signed [DATA_W-1:0] value, input logic is_last);
      row_sample_t item;
      item.value = value;
      item.last = is_last;
      samples_pending.push_back(item);
   endtask

   task automatic queue_row(input int n, input fill_style_t style);
      logic signed [DATA_W-1:0] v, flat;
      flat = $urandom;
      for (int k = 0; k < n; k++) begin
         case (style)
            FILL_WIDE: begin
               v = $urandom;
            end
            FILL_NARROW: begin
               v = $urandom_range(0, 8191) - 4096;
            end
            FILL_FLAT: begin
               v = flat;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: v = VALUE_MIN;
                  1: v = VALUE_MAX;
                  2: v = '0;
                  default: v = -1;
               endcase
            end
         endcase
         push_sample(v, k == n - 1);
      end
   endtask

   // Waits until every item is in and every summary is out, then lets the block go quiet.
   task automatic settle;
      do @(posedge clock);
      while (samples_pending.size() != 0 || req_valid || summaries_due.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SWEEPS_PER_ROUND: sweeps_cfg = value[SWEEPS_W-1:0];
         CSR_ALLOWED_SPREAD:   spread_cfg = value[SPREAD_LIMIT_W-1:0];
         CSR_MAX_ROUNDS:       rounds_cfg = value[ROUNDS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int made, n, pick;
      bit wide;
      logic [CSR_DATA_W-1:0] sw, sp, rd;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Settings as they come out of reset.
      push_sample(0, 1'b0);
      push_sample(100, 1'b1);
      push_sample(VALUE_MAX, 1'b1);
      settle();

      // Extreme samples, a row at rest and negative truncation.
      write_reg(CSR_SWEEPS_PER_ROUND, 2);
      write_reg(CSR_ALLOWED_SPREAD, 0);
      write_reg(CSR_MAX_ROUNDS, 3);
      push_sample(VALUE_MIN, 1'b0);
      push_sample(VALUE_MAX, 1'b0);
      push_sample(VALUE_MIN, 1'b1);
      push_sample(VALUE_MAX, 1'b0);
      push_sample(VALUE_MAX, 1'b1);
      push_sample(-7, 1'b0);
      push_sample(7, 1'b0);
      push_sample(-3, 1'b0);
      push_sample(5, 1'b1);
      settle();

      // With no sweeps a round only measures the row.
      write_reg(CSR_SWEEPS_PER_ROUND, 0);
      write_reg(CSR_ALLOWED_SPREAD, 1000);
      write_reg(CSR_MAX_ROUNDS, 5);
      push_sample(0, 1'b0);
      push_sample(5000, 1'b1);
      push_sample(10, 1'b0);
      push_sample(20, 1'b1);
      settle();

      // A round limit of zero acts as one round.
      write_reg(CSR_SWEEPS_PER_ROUND, 1);
      write_reg(CSR_ALLOWED_SPREAD, 0);
      write_reg(CSR_MAX_ROUNDS, 0);
      for (int k = 1; k <= 5; k++) push_sample(k, k == 5);
      settle();

      // Largest settings; short rows settle fast, so the rest shortcut keeps this cheap.
      write_reg(CSR_SWEEPS_PER_ROUND, 16'hFFFF);
      write_reg(CSR_ALLOWED_SPREAD, 31'h7FFF_FFFF);
      write_reg(CSR_MAX_ROUNDS, 16'hFFFF);
      push_sample(VALUE_MIN, 1'b0);
      push_sample(VALUE_MAX, 1'b1);
      settle();
      write_reg(CSR_ALLOWED_SPREAD, 0);
      push_sample(100, 1'b0);
      push_sample(-50, 1'b1);
      settle();

      // A row longer than the memory: the extra samples are dropped.
      write_reg(CSR_SWEEPS_PER_ROUND, 1);
      write_reg(CSR_MAX_ROUNDS, 1);
      write_reg(CSR_ALLOWED_SPREAD, 31'($urandom));
      queue_row(POINTS + 6, FILL_WIDE);
      settle();

      made = 0;
      while (made < 1150) begin
         calm = (made >= 980);
         pick = $urandom_range(0, 9);
         sw = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(1, 6);
         pick = $urandom_range(0, 9);
         sp = (pick <= 1) ? 0 : (pick <= 3) ? 31'h7FFF_FFFF :
              31'($urandom) >> $urandom_range(0, 30);
         pick = $urandom_range(0, 9);
         rd = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(1, 4);
         // Huge sweep or round counts are only affordable on very short rows.
         wide = (sw > 6) || (rd > 4);
         write_reg(CSR_SWEEPS_PER_ROUND, sw);
         write_reg(CSR_ALLOWED_SPREAD, sp);
         write_reg(CSR_MAX_ROUNDS, rd);
         repeat ($urandom_range(8, 16)) begin
            if (wide) n = $urandom_range(1, 3);
            else if ($urandom_range(0, 19) == 0) n = $urandom_range(13, 40);
            else n = $urandom_range(1, 12);
            queue_row(n, fill_style_t'($urandom_range(0, 3)));
            made += n;
         end
         settle();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_ram.sv
hw/rtl/heat_stencil_converge_core.sv
test/tb_heat_stencil_converge_core.sv
